// ===== hw/rtl/waypoint_graph_astar_defines.svh =====
// Assertion macros for the waypoint graph block.
`ifndef WAYPOINT_GRAPH_ASTAR_DEFINES_SVH
`define WAYPOINT_GRAPH_ASTAR_DEFINES_SVH
`ifndef ASSERT_OFF
`define WGA_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("wga assertion failed");
`define WGA_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("wga assertion failed");
`else
`define WGA_ASSERT_IMP(lbl, pre, post)
`define WGA_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/wga_pkg.sv =====
`timescale 1ns / 1ps
package wga_pkg;
    localparam int MAX_NODES_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;
    localparam int G_BITS = 22;
    localparam int F_BITS = 23;

    localparam logic [2:0] K_REG  = 3'd0;
    localparam logic [2:0] K_CONN = 3'd1;
    localparam logic [2:0] K_DISC = 3'd2;
    localparam logic [2:0] K_NEAR = 3'd3;
    localparam logic [2:0] K_PATH = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_SAME    = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_NO_PATH = 3'd4;
endpackage

// ===== hw/rtl/wga_if.sv =====
`timescale 1ns / 1ps
interface wga_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [4:0]         node_a;
    logic [4:0]         node_b;
    logic               both_ways;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    modport source (output valid, kind, node_a, node_b, both_ways, pos_x, pos_y, pos_z,
                    input ready);
    modport sink (input valid, kind, node_a, node_b, both_ways, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface wga_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] node_id;
    logic       last;
    modport source (output valid, status, node_id, last, input ready);
    modport sink (input valid, status, node_id, last, output ready);
endinterface

// ===== hw/rtl/waypoint_graph_astar.sv =====
`timescale 1ns / 1ps
// Waypoint graph with A* path search.
// Command channel i_cmd (valid/ready): register a waypoint, connect or
// disconnect two ids, nearest-waypoint query, path query. Result channel
// o_res (valid/ready): status, node_id, last; a path gives one item per id,
// start first, last set on the goal; every other command gives one item.
// One command is in work at a time; i_cmd.ready is high only while idle.
// Nearest runs one 3-axis squared distance through a single multiplier
// per stored waypoint. A path query runs per expanded node a select pass
// over the search memory plus, per linked neighbor, one or two distances
// (one root bit per cycle), then traces the path back and emits its ids.
// Reset clears the valid marks and all control state; the node table and the
// search memory need no clearing pass, a row being read only once written.
// A stalled receiver holds the result register and the block waits on it.
`include "waypoint_graph_astar_defines.svh"
module waypoint_graph_astar #(
    parameter int MAX_NODES  = wga_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = wga_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wga_cmd_if.sink    i_cmd,
    wga_res_if.source  o_res
);
    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = COORD_BITS;
    localparam int PW   = 3 * CW;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW;
    localparam int RW   = CW + 2;
    localparam int ACCW = 2 * RW;
    localparam int GB   = wga_pkg::G_BITS;
    localparam int FB   = wga_pkg::F_BITS;
    localparam int SCW  = $clog2(RW);
    localparam logic [NW-1:0] LASTI = NW'(MAX_NODES - 1);

    typedef struct packed {
        logic [MAX_NODES-1:0] row;
        logic [PW-1:0]        pos;
    } t_nt;

    typedef struct packed {
        logic [GB-1:0] g;
        logic [FB-1:0] f;
        logic [NW-1:0] parent;
        logic [NW-1:0] stamp;
        logic [NW-1:0] next;
    } t_rec;

    localparam logic [4:0] S_IDLE = 5'd0,  S_DEC = 5'd1,  S_SEND = 5'd2,
                           S_LNK_A = 5'd3, S_LNK_B = 5'd4, S_NR_RD = 5'd5,
                           S_NR_LD = 5'd6, S_NR_CMP = 5'd7, S_DSUB = 5'd8,
                           S_DMUL = 5'd9, S_DACC = 5'd10, S_SQRT = 5'd11,
                           S_PS_G = 5'd12, S_PS_S = 5'd13, S_PS_INIT = 5'd14,
                           S_SL_INIT = 5'd15, S_SL_RD = 5'd16, S_SL_CMP = 5'd17,
                           S_SL_END = 5'd18, S_EX_LD = 5'd19, S_NB_RD = 5'd20,
                           S_NB_LD = 5'd21, S_NB_G = 5'd22, S_NB_UPD = 5'd23,
                           S_BK_RD = 5'd24, S_BK_WR = 5'd25, S_EM = 5'd26,
                           S_EM_RD = 5'd27, S_EM_LD = 5'd28;

    logic [4:0] r_state, r_ret, r_dret;

    // command latch
    logic [2:0]    r_kind;
    logic [4:0]    r_a, r_b;
    logic          r_both;
    logic [PW-1:0] r_qpos;

    // result staging and output register
    logic [2:0] r_st, r_ost;
    logic [4:0] r_sid, r_oid;
    logic       r_slast, r_olast, r_ov;

    logic [MAX_NODES-1:0] r_valid, r_open, r_closed, r_seen;

    // distance unit
    logic [PW-1:0]         r_pa, r_pb;
    logic [1:0]            r_ax;
    logic signed [DW-1:0]  r_diff;
    logic [SQW-1:0]        r_prod;
    logic [ACCW-1:0]       r_acc;
    logic                  r_dsq;
    logic [ACCW-1:0]       r_rad;
    logic [RW+1:0]         r_rem;
    logic [RW-1:0]         r_root;
    logic [SCW-1:0]        r_sc;

    // scans and search
    logic [NW-1:0]        r_i, r_best, r_cur, r_n, r_c, r_child;
    logic                 r_found;
    logic [ACCW-1:0]      r_bd;
    logic [FB-1:0]        r_bf;
    logic [NW-1:0]        r_bs;
    logic [NW:0]          r_stamp;
    logic [GB-1:0]        r_gcur, r_ng;
    logic [PW-1:0]        r_gpos, r_cpos, r_npos;
    logic [MAX_NODES-1:0] r_row;
    t_rec                 r_nrec;

    // memories
    logic          nt_we, rec_we;
    logic [NW-1:0] nt_waddr, nt_raddr, rec_waddr, rec_raddr;
    t_nt           nt_wdata, nt_q;
    t_rec          rec_wdata, rec_q;

    wga_ram #(.WIDTH($bits(t_nt)), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (nt_waddr),
        .i_wdata (nt_wdata),
        .i_raddr (nt_raddr),
        .o_rdata (nt_q)
    );

    wga_ram #(.WIDTH($bits(t_rec)), .DEPTH(MAX_NODES)) u_search_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rec_raddr),
        .o_rdata (rec_q)
    );

    // decode helpers
    logic [NW-1:0] a_idx, b_idx;
    logic          a_ok, b_ok, a_in;
    assign a_idx = NW'(r_a);
    assign b_idx = NW'(r_b);
    assign a_in  = 32'(r_a) < 32'(MAX_NODES);
    assign a_ok  = a_in && r_valid[a_idx];
    assign b_ok  = (32'(r_b) < 32'(MAX_NODES)) && r_valid[b_idx];

    logic [31:0]   x32, y32, z32;
    logic [PW-1:0] in_pos;
    assign x32    = {16'b0, i_cmd.pos_x};
    assign y32    = {16'b0, i_cmd.pos_y};
    assign z32    = {16'b0, i_cmd.pos_z};
    assign in_pos = {z32[CW-1:0], y32[CW-1:0], x32[CW-1:0]};

    // distance datapath
    logic [CW-1:0]         pa_c, pb_c;
    logic signed [DW-1:0]  diff;
    logic signed [SQW-1:0] prod_s;
    logic [ACCW-1:0]       acc_sum;
    logic [RW+1:0]         rem_t, trial;
    logic                  rem_ge;
    assign pa_c    = r_pa[32'(r_ax) * CW +: CW];
    assign pb_c    = r_pb[32'(r_ax) * CW +: CW];
    assign diff    = $signed({pa_c[CW-1], pa_c}) - $signed({pb_c[CW-1], pb_c});
    assign prod_s  = r_diff * r_diff;
    assign acc_sum = r_acc + ACCW'(r_prod);
    assign rem_t   = {r_rem[RW-1:0], r_rad[ACCW-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign rem_ge  = rem_t >= trial;

    // saturating cost sums
    logic [GB:0]   gsum;
    logic [GB-1:0] ng;
    logic [FB:0]   fsum;
    logic [FB-1:0] fsat;
    assign gsum = {1'b0, r_gcur} + (GB+1)'(r_root);
    assign ng   = gsum[GB] ? '1 : gsum[GB-1:0];
    assign fsum = (FB+1)'(r_ng) + (FB+1)'(r_root);
    assign fsat = fsum[FB] ? '1 : fsum[FB-1:0];

    logic sel_better, nb_take, nb_skip;
    assign sel_better = !r_found || (rec_q.f < r_bf) ||
                        ((rec_q.f == r_bf) && (rec_q.stamp < r_bs));
    assign nb_take    = r_row[r_n] && r_valid[r_n] && !r_closed[r_n];
    assign nb_skip    = r_seen[r_n] && !(ng < r_nrec.g);

    logic [MAX_NODES-1:0] bit_a, bit_b, row_a_new, row_b_new;
    assign bit_a     = MAX_NODES'(1) << a_idx;
    assign bit_b     = MAX_NODES'(1) << b_idx;
    assign row_a_new = (r_kind == wga_pkg::K_CONN) ? (nt_q.row | bit_b) : (nt_q.row & ~bit_b);
    assign row_b_new = (r_kind == wga_pkg::K_CONN) ? (nt_q.row | bit_a) : (nt_q.row & ~bit_a);

    // memory port control
    always_comb begin
        nt_we     = 1'b0;
        nt_waddr  = a_idx;
        nt_wdata  = nt_q;
        nt_raddr  = '0;
        rec_we    = 1'b0;
        rec_waddr = r_n;
        rec_wdata = rec_q;
        rec_raddr = '0;
        unique case (r_state)
            S_DEC: begin
                if (r_kind == wga_pkg::K_REG && a_in && !r_valid[a_idx]) begin
                    nt_we    = 1'b1;
                    nt_wdata = '{row: '0, pos: r_qpos};
                end
                if (r_kind == wga_pkg::K_PATH) begin
                    nt_raddr = b_idx;
                end else begin
                    nt_raddr = a_idx;
                end
            end
            S_LNK_A: begin
                nt_we        = 1'b1;
                nt_wdata.row = row_a_new;
                nt_raddr     = b_idx;
            end
            S_LNK_B: begin
                nt_we        = 1'b1;
                nt_waddr     = b_idx;
                nt_wdata.row = row_b_new;
            end
            S_NR_RD:  nt_raddr = r_i;
            S_PS_G:   nt_raddr = a_idx;
            S_PS_INIT: begin
                rec_we    = 1'b1;
                rec_waddr = a_idx;
                rec_wdata = '{g: '0, f: fsat, parent: '0, stamp: '0, next: '0};
            end
            S_SL_RD:  rec_raddr = r_i;
            S_SL_END: begin
                rec_raddr = r_best;
                nt_raddr  = r_best;
            end
            S_NB_RD: begin
                rec_raddr = r_n;
                nt_raddr  = r_n;
            end
            S_NB_UPD: begin
                rec_we    = 1'b1;
                rec_wdata = '{g: r_ng, f: fsat, parent: r_cur,
                              stamp: r_open[r_n] ? r_nrec.stamp : r_stamp[NW-1:0],
                              next: '0};
            end
            S_BK_RD:  rec_raddr = r_c;
            S_BK_WR: begin
                rec_we         = 1'b1;
                rec_waddr      = r_c;
                rec_wdata.next = r_child;
            end
            S_EM_RD:  rec_raddr = r_c;
            default: ;
        endcase
    end

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_ov;
    assign o_res.status  = r_ost;
    assign o_res.node_id = r_oid;
    assign o_res.last    = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_valid  <= '0;
            r_open   <= '0;
            r_closed <= '0;
            r_seen   <= '0;
        end else begin
            if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_kind  <= i_cmd.kind;
                        r_a     <= i_cmd.node_a;
                        r_b     <= i_cmd.node_b;
                        r_both  <= i_cmd.both_ways;
                        r_qpos  <= in_pos;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_sid   <= r_a;
                    r_slast <= 1'b1;
                    r_ret   <= S_IDLE;
                    r_st    <= wga_pkg::ST_OK;
                    r_state <= S_SEND;
                    unique case (r_kind) inside
                        wga_pkg::K_REG: begin
                            if (!a_in) begin
                                r_st <= wga_pkg::ST_MISSING;
                            end else if (r_valid[a_idx]) begin
                                r_st <= wga_pkg::ST_PRESENT;
                            end else begin
                                r_valid[a_idx] <= 1'b1;
                            end
                        end
                        wga_pkg::K_CONN, wga_pkg::K_DISC: begin
                            if (!a_ok || !b_ok) begin
                                r_st <= wga_pkg::ST_MISSING;
                            end else if (r_a == r_b) begin
                                r_st <= wga_pkg::ST_SAME;
                            end else begin
                                r_state <= S_LNK_A;
                            end
                        end
                        wga_pkg::K_NEAR: begin
                            if (r_valid == '0) begin
                                r_st  <= wga_pkg::ST_MISSING;
                                r_sid <= '0;
                            end else begin
                                r_i     <= '0;
                                r_found <= 1'b0;
                                r_state <= S_NR_RD;
                            end
                        end
                        wga_pkg::K_PATH: begin
                            if (!a_ok || !b_ok) begin
                                r_st <= wga_pkg::ST_MISSING;
                            end else if (r_a != r_b) begin
                                r_open   <= '0;
                                r_closed <= '0;
                                r_seen   <= '0;
                                r_state  <= S_PS_G;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SEND: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_ost   <= r_st;
                        r_oid   <= r_sid;
                        r_olast <= r_slast;
                        r_state <= r_ret;
                    end
                end
                S_LNK_A: begin
                    r_state <= r_both ? S_LNK_B : S_SEND;
                end
                S_LNK_B: r_state <= S_SEND;
                // nearest waypoint scan
                S_NR_RD: begin
                    if (r_valid[r_i]) begin
                        r_state <= S_NR_LD;
                    end else if (r_i == LASTI) begin
                        r_sid   <= 5'(r_best);
                        r_state <= S_SEND;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_NR_LD: begin
                    r_pa    <= nt_q.pos;
                    r_pb    <= r_qpos;
                    r_ax    <= '0;
                    r_acc   <= '0;
                    r_dsq   <= 1'b0;
                    r_dret  <= S_NR_CMP;
                    r_state <= S_DSUB;
                end
                S_NR_CMP: begin
                    if (!r_found || r_acc < r_bd) begin
                        r_found <= 1'b1;
                        r_bd    <= r_acc;
                        r_best  <= r_i;
                    end
                    if (r_i == LASTI) begin
                        r_sid   <= (!r_found || r_acc < r_bd) ? 5'(r_i) : 5'(r_best);
                        r_state <= S_SEND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_NR_RD;
                    end
                end
                // shared distance unit: three squares, then optional root
                S_DSUB: begin
                    r_diff  <= diff;
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_prod  <= SQW'(unsigned'(prod_s));
                    r_state <= S_DACC;
                end
                S_DACC: begin
                    r_acc <= acc_sum;
                    if (r_ax == 2'd2) begin
                        if (r_dsq) begin
                            r_rad   <= acc_sum;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_sc    <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_state <= r_dret;
                        end
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_DSUB;
                    end
                end
                S_SQRT: begin
                    r_rad <= {r_rad[ACCW-3:0], 2'b00};
                    if (rem_ge) begin
                        r_rem  <= rem_t - trial;
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_t;
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                    r_sc <= r_sc + 1'b1;
                    if (r_sc == SCW'(RW - 1)) begin
                        r_state <= r_dret;
                    end
                end
                // path search setup
                S_PS_G: begin
                    r_gpos  <= nt_q.pos;
                    r_state <= S_PS_S;
                end
                S_PS_S: begin
                    r_pa    <= nt_q.pos;
                    r_pb    <= r_gpos;
                    r_ng    <= '0;
                    r_ax    <= '0;
                    r_acc   <= '0;
                    r_dsq   <= 1'b1;
                    r_dret  <= S_PS_INIT;
                    r_state <= S_DSUB;
                end
                S_PS_INIT: begin
                    r_open[a_idx] <= 1'b1;
                    r_seen[a_idx] <= 1'b1;
                    r_stamp       <= (NW+1)'(1);
                    r_state       <= S_SL_INIT;
                end
                // pick the open node with lowest f, earliest stamp on a tie
                S_SL_INIT: begin
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SL_RD;
                end
                S_SL_RD: begin
                    if (r_open[r_i]) begin
                        r_state <= S_SL_CMP;
                    end else if (r_i == LASTI) begin
                        r_state <= S_SL_END;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SL_CMP: begin
                    if (sel_better) begin
                        r_found <= 1'b1;
                        r_bf    <= rec_q.f;
                        r_bs    <= rec_q.stamp;
                        r_best  <= r_i;
                    end
                    if (r_i == LASTI) begin
                        r_state <= S_SL_END;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SL_RD;
                    end
                end
                S_SL_END: begin
                    if (!r_found) begin
                        r_st    <= wga_pkg::ST_NO_PATH;
                        r_sid   <= r_a;
                        r_slast <= 1'b1;
                        r_ret   <= S_IDLE;
                        r_state <= S_SEND;
                    end else begin
                        r_open[r_best]   <= 1'b0;
                        r_closed[r_best] <= 1'b1;
                        r_cur            <= r_best;
                        r_c              <= r_best;
                        r_state          <= (r_best == b_idx) ? S_BK_RD : S_EX_LD;
                    end
                end
                S_EX_LD: begin
                    r_gcur  <= rec_q.g;
                    r_cpos  <= nt_q.pos;
                    r_row   <= nt_q.row;
                    r_n     <= '0;
                    r_state <= S_NB_RD;
                end
                // neighbor scan in ascending id order
                S_NB_RD: begin
                    if (nb_take) begin
                        r_state <= S_NB_LD;
                    end else if (r_n == LASTI) begin
                        r_state <= S_SL_INIT;
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                end
                S_NB_LD: begin
                    r_npos  <= nt_q.pos;
                    r_nrec  <= rec_q;
                    r_pa    <= r_cpos;
                    r_pb    <= nt_q.pos;
                    r_ax    <= '0;
                    r_acc   <= '0;
                    r_dsq   <= 1'b1;
                    r_dret  <= S_NB_G;
                    r_state <= S_DSUB;
                end
                S_NB_G: begin
                    if (nb_skip) begin
                        if (r_n == LASTI) begin
                            r_state <= S_SL_INIT;
                        end else begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_NB_RD;
                        end
                    end else begin
                        r_ng    <= ng;
                        r_pa    <= r_npos;
                        r_pb    <= r_gpos;
                        r_ax    <= '0;
                        r_acc   <= '0;
                        r_dret  <= S_NB_UPD;
                        r_state <= S_DSUB;
                    end
                end
                S_NB_UPD: begin
                    if (!r_open[r_n]) begin
                        r_stamp <= r_stamp + 1'b1;
                    end
                    r_open[r_n] <= 1'b1;
                    r_seen[r_n] <= 1'b1;
                    if (r_n == LASTI) begin
                        r_state <= S_SL_INIT;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_NB_RD;
                    end
                end
                // walk parents back, leaving a forward link in each record
                S_BK_RD: r_state <= S_BK_WR;
                S_BK_WR: begin
                    if (r_c == a_idx) begin
                        r_state <= S_EM;
                    end else begin
                        r_child <= r_c;
                        r_c     <= rec_q.parent;
                        r_state <= S_BK_RD;
                    end
                end
                S_EM: begin
                    r_st    <= wga_pkg::ST_OK;
                    r_sid   <= 5'(r_c);
                    r_slast <= (r_c == b_idx);
                    r_ret   <= (r_c == b_idx) ? S_IDLE : S_EM_RD;
                    r_state <= S_SEND;
                end
                S_EM_RD: r_state <= S_EM_LD;
                S_EM_LD: begin
                    r_c     <= rec_q.next;
                    r_state <= S_EM;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `WGA_ASSERT_NXT(a_busy_after_accept, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `WGA_ASSERT_IMP(a_open_closed_disjoint, 1'b1, (r_open & r_closed) == '0)
    `WGA_ASSERT_IMP(a_flags_seen, 1'b1, ((r_open | r_closed) & ~r_seen) == '0)
    `WGA_ASSERT_IMP(a_open_valid, 1'b1, (r_open & ~r_valid) == '0)
endmodule

// ===== hw/rtl/wga_ram.sv =====
`timescale 1ns / 1ps
module wga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
